// ----- rtl/sswgp_pkg.sv -----
// Shared constants, types, command codes and the quarter-sine table of the channel strip.
`timescale 1ns / 1ps

package sswgp_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int SINE_DEPTH    = 256;
  localparam int MAX_BLOCK_DEF = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BLOCK_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TARGET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TARGET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_TARGET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCED      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_MASTER     = 3'd7;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  localparam u64_t HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [17:0] coef_t;
  typedef coef_t sine_tab_t [SINE_DEPTH+1];

  // Restoring long division, evaluated only while the constant table is built.
  function automatic u64_t udiv(u64_t num, u64_t den);
    u64_t q;
    u64_t r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-sine table in Q1.16, each entry from an 8-term Taylor series in Q30.
  function automatic sine_tab_t sine_build();
    sine_tab_t tab;
    u64_t      th;
    u64_t      x2;
    u64_t      term;
    s64_t      sum;
    s64_t      v;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      th   = udiv(HALF_PI_Q30 * u64_t'(k) + u64_t'(SINE_DEPTH >> 1), u64_t'(SINE_DEPTH));
      x2   = (th * th) >> 30;
      term = th;
      sum  = s64_t'(th);
      for (int n = 1; n <= 7; n++) begin
        term = udiv((term * x2) >> 30, u64_t'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) begin
          sum = sum - s64_t'(term);
        end else begin
          sum = sum + s64_t'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 8192) >>> 14;
      tab[k] = (v > 65536) ? 18'sd65536 : coef_t'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = sine_build();

  typedef enum logic [4:0] {
    OP_APP_W, OP_APP_G, OP_APP_M, OP_APP_P,
    OP_SIN0, OP_COS0, OP_SIN1, OP_COS1,
    OP_T,
    OP_LERP_W, OP_LERP_G, OP_LERP_M,
    OP_LERP_LL, OP_LERP_RL, OP_LERP_LR, OP_LERP_RR,
    OP_WID, OP_GAIN, OP_AG, OP_BG,
    OP_PAN1, OP_PAN2, OP_PAN3, OP_PAN4,
    OP_SQ_L, OP_SQ_R, OP_SQ_OL, OP_SQ_OR
  } op_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic wb;
    logic fin;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic out_hold;
  } sts_t;

endpackage

// ----- rtl/sswgp_ctrl.sv -----
// Sequencer that steps the datapath through its multiply and write-back operations per item.
`timescale 1ns / 1ps

module sswgp_ctrl
  import sswgp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_WB, ST_FIN} state_e;

  state_e state_q;
  op_e    op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_APP_W;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            // The block-start operations run only on the first item of a block.
            op_q    <= sts_i.first ? OP_APP_W : OP_T;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_WB;
        end
        ST_WB: begin
          if (op_q == OP_SQ_OR) begin
            state_q <= ST_FIN;
          end else begin
            op_q    <= op_e'(op_q + 5'd1);
            state_q <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (!sts_i.out_hold) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  assign cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.mul  = (state_q == ST_MUL);
  assign cmd_o.wb   = (state_q == ST_WB);
  assign cmd_o.fin  = (state_q == ST_FIN) && !sts_i.out_hold;
  assign cmd_o.op   = op_q;

endmodule

// ----- rtl/sswgp_dpath.sv -----
// Datapath: configuration, control ramps, pan matrices, shared multiplier, meters, output register.
`timescale 1ns / 1ps

module sswgp_dpath
  import sswgp_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          block_end_o,
  output logic [23:0]                   pre_peak_left_o,
  output logic [23:0]                   pre_peak_right_o,
  output logic [23:0]                   post_peak_left_o,
  output logic [23:0]                   post_peak_right_o,
  output logic [58:0]                   pre_energy_o,
  output logic [58:0]                   post_energy_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int POS_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int IDX_W  = $clog2(SINE_DEPTH + 1);
  localparam logic [16:0] MAX_LEN = 17'(MAX_BLOCK);
  localparam logic [59:0] ECAP    = (60'd1 << 59) - 60'd1;
  localparam logic signed [59:0] SMAX = (60'sd1 <<< (SB - 1)) - 60'sd1;
  localparam logic signed [59:0] SMIN = -(60'sd1 <<< (SB - 1));

  function automatic logic signed [59:0] rnd(input logic signed [59:0] v, input int sh);
    return (v + (60'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [SB-1:0] sat(input logic signed [59:0] v);
    logic signed [59:0] c;
    c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
    return c[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] v);
    logic signed [SB:0] e;
    e = (SB + 1)'(v);
    return v[SB-1] ? SB'(-e) : SB'(e);
  endfunction

  // Configuration registers.
  logic [12:0]        blen_q;
  logic [16:0]        inv_q;
  logic [15:0]        coef_q;
  logic [15:0]        wt_q;
  logic [17:0]        gt_q;
  logic signed [15:0] pt_q;
  logic               sil_q;
  logic               mas_q;

  // Control and meter state.
  logic [POS_W-1:0]   pos_q;
  logic signed [19:0] now_q [4];
  logic signed [19:0] end_q [4];
  logic signed [17:0] cs_q [4];
  logic signed [17:0] ce_q [4];
  logic [SB-1:0]      peak_q [4];
  logic [58:0]        eacc_q [2];
  logic               out_valid_q;

  // Working registers of one item.
  logic signed [SB-1:0] l_q, r_q, ol_q, or_q;
  logic signed [19:0]   lv_q [7];
  logic [16:0]          t_q;
  logic signed [17:0]   s_q;
  logic signed [31:0]   a_q, b_q;
  logic signed [19:0]   g_q;
  logic signed [57:0]   acc_q;
  logic signed [56:0]   prod_q;

  // Output register.
  logic signed [SB-1:0] left_out_q, right_out_q;
  logic                 block_end_q;
  logic [23:0]          opk_q [4];
  logic [58:0]          oen_q [2];

  // Targets and block position.
  logic signed [19:0] tgt [4];
  logic signed [15:0] ptm;
  logic [16:0]        len;
  logic               last;

  always_comb begin
    ptm    = mas_q ? 16'sd0 : pt_q;
    tgt[0] = (wt_q > 16'd32768) ? 20'sd32768 : 20'($signed({1'b0, wt_q}));
    tgt[1] = 20'($signed({1'b0, gt_q}));
    tgt[2] = sil_q ? 20'sd0 : 20'sd65536;
    if (ptm > 16'sd16384) begin
      tgt[3] = 20'sd16384;
    end else if (ptm < -16'sd16384) begin
      tgt[3] = -20'sd16384;
    end else begin
      tgt[3] = 20'(ptm);
    end
    if (blen_q == 13'd0) begin
      len = 17'd1;
    end else if (17'(blen_q) > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = 17'(blen_q);
    end
    last = (17'(pos_q) + 17'd1) >= len;
  end

  // Operand selection.
  logic [1:0]         csel;
  logic [1:0]         msel;
  logic               is_lerp_c;
  logic signed [19:0] cur_c, tgt_c, lerp_s, lerp_e;
  logic [19:0]        app_d;
  logic signed [20:0] lerp_d;

  always_comb begin
    csel      = 2'd0;
    msel      = 2'd0;
    is_lerp_c = 1'b1;
    case (cmd_i.op)
      OP_APP_W, OP_LERP_W: csel = 2'd0;
      OP_APP_G, OP_LERP_G: csel = 2'd1;
      OP_APP_M, OP_LERP_M: csel = 2'd2;
      OP_APP_P:            csel = 2'd3;
      OP_LERP_LL: begin msel = 2'd0; is_lerp_c = 1'b0; end
      OP_LERP_RL: begin msel = 2'd1; is_lerp_c = 1'b0; end
      OP_LERP_LR: begin msel = 2'd2; is_lerp_c = 1'b0; end
      OP_LERP_RR: begin msel = 2'd3; is_lerp_c = 1'b0; end
      default: ;
    endcase
    cur_c  = now_q[csel];
    tgt_c  = tgt[csel];
    app_d  = (cur_c >= tgt_c) ? 20'(cur_c - tgt_c) : 20'(tgt_c - cur_c);
    lerp_s = is_lerp_c ? cur_c : 20'(cs_q[msel]);
    lerp_e = is_lerp_c ? end_q[csel] : 20'(ce_q[msel]);
    lerp_d = 21'(lerp_e) - 21'(lerp_s);
  end

  // Sine lookup with linear interpolation; cos(x) is sin(1 - x).
  logic               sin_end, sin_cos;
  logic signed [19:0] sin_p;
  logic [14:0]        pabs, su;
  logic [31:0]        spos;
  logic [17:0]        sidx;
  logic               sidx_sat;
  logic [IDX_W-1:0]   idx_c;
  logic signed [17:0] tab_lo, tab_hi;
  logic signed [17:0] sin_val;
  logic signed [59:0] sin_frac;
  logic signed [17:0] mat [4];

  always_comb begin
    sin_end  = (cmd_i.op == OP_SIN1) || (cmd_i.op == OP_COS1);
    sin_cos  = (cmd_i.op == OP_COS0) || (cmd_i.op == OP_COS1);
    sin_p    = sin_end ? end_q[3] : now_q[3];
    pabs     = sin_p[19] ? 15'(-sin_p) : 15'(sin_p);
    su       = sin_cos ? 15'(15'd16384 - pabs) : pabs;
    spos     = 32'(su) * 32'(SINE_DEPTH);
    sidx     = spos[31:14];
    sidx_sat = sidx >= 18'(SINE_DEPTH);
    idx_c    = sidx_sat ? IDX_W'(SINE_DEPTH - 1) : sidx[IDX_W-1:0];
    tab_lo   = SINE_TAB[idx_c];
    tab_hi   = SINE_TAB[idx_c + 1'b1];
    sin_frac = rnd(60'(prod_q), 14);
    sin_val  = sidx_sat ? SINE_TAB[SINE_DEPTH] : 18'(60'(tab_lo) + sin_frac);
    // Matrix order is ll, rl, lr, rr.
    if (sin_p == 20'sd0) begin
      mat[0] = 18'sd65536; mat[1] = 18'sd0; mat[2] = 18'sd0; mat[3] = 18'sd65536;
    end else if (sin_p < 20'sd0) begin
      mat[0] = 18'sd65536; mat[1] = s_q; mat[2] = 18'sd0; mat[3] = sin_val;
    end else begin
      mat[0] = sin_val; mat[1] = 18'sd0; mat[2] = s_q; mat[3] = 18'sd65536;
    end
  end

  // Shared multiplier operands.
  logic signed [31:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [24:0] sum_lr, dif_lr;

  always_comb begin
    sum_lr = 25'(l_q) + 25'(r_q);
    dif_lr = 25'(l_q) - 25'(r_q);
    mul_a  = 32'sd0;
    mul_b  = 25'sd0;
    unique case (cmd_i.op)
      OP_APP_W, OP_APP_G, OP_APP_M, OP_APP_P: begin
        mul_a = 32'($signed({1'b0, app_d}));
        mul_b = 25'($signed({1'b0, coef_q}));
      end
      OP_SIN0, OP_COS0, OP_SIN1, OP_COS1: begin
        mul_a = sidx_sat ? 32'sd0 : 32'(tab_hi - tab_lo);
        mul_b = 25'($signed({1'b0, spos[13:0]}));
      end
      OP_T: begin
        mul_a = 32'($signed({1'b0, pos_q}));
        mul_b = 25'($signed({1'b0, inv_q}));
      end
      OP_LERP_W, OP_LERP_G, OP_LERP_M,
      OP_LERP_LL, OP_LERP_RL, OP_LERP_LR, OP_LERP_RR: begin
        mul_a = 32'(lerp_d);
        mul_b = 25'($signed({1'b0, t_q}));
      end
      OP_WID:   begin mul_a = 32'(dif_lr); mul_b = 25'(lv_q[0]); end
      OP_GAIN:  begin mul_a = 32'(lv_q[1]); mul_b = 25'(lv_q[2]); end
      OP_AG:    begin mul_a = a_q; mul_b = 25'(g_q); end
      OP_BG:    begin mul_a = b_q; mul_b = 25'(g_q); end
      OP_PAN1:  begin mul_a = a_q; mul_b = 25'(lv_q[3]); end
      OP_PAN2:  begin mul_a = b_q; mul_b = 25'(lv_q[4]); end
      OP_PAN3:  begin mul_a = b_q; mul_b = 25'(lv_q[6]); end
      OP_PAN4:  begin mul_a = a_q; mul_b = 25'(lv_q[5]); end
      OP_SQ_L:  begin mul_a = 32'(l_q); mul_b = 25'(l_q); end
      OP_SQ_R:  begin mul_a = 32'(r_q); mul_b = 25'(r_q); end
      OP_SQ_OL: begin mul_a = 32'(ol_q); mul_b = 25'(ol_q); end
      OP_SQ_OR: begin mul_a = 32'(or_q); mul_b = 25'(or_q); end
      default: ;
    endcase
  end

  // Write-back helpers.
  logic signed [59:0] app_mag, rnd16, m2s, wid_a, wid_b, pan_sum, e_sq;
  logic [59:0]        e_sum;
  logic [58:0]        e_new;
  logic [SB-1:0]      pk_n [4];

  always_comb begin
    app_mag = rnd(60'(prod_q), 16);
    rnd16   = rnd(60'(prod_q), 16);
    m2s     = 60'(sum_lr) <<< 14;
    wid_a   = rnd(m2s + 60'(prod_q), 15);
    wid_b   = rnd(m2s - 60'(prod_q), 15);
    pan_sum = rnd(60'(acc_q) + 60'(prod_q), 16);
    e_sq    = 60'(acc_q) + 60'(prod_q);
    e_sum   = 60'(eacc_q[cmd_i.op == OP_SQ_OR]) + 60'(e_sq);
    e_new   = (e_sum > ECAP) ? ECAP[58:0] : e_sum[58:0];
    pk_n[0] = (mag(l_q) > peak_q[0]) ? mag(l_q) : peak_q[0];
    pk_n[1] = (mag(r_q) > peak_q[1]) ? mag(r_q) : peak_q[1];
    pk_n[2] = (mag(ol_q) > peak_q[2]) ? mag(ol_q) : peak_q[2];
    pk_n[3] = (mag(or_q) > peak_q[3]) ? mag(or_q) : peak_q[3];
  end

  // Control state, configuration and meters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q      <= 13'd128;
      inv_q       <= 17'd512;
      coef_q      <= 16'd0;
      wt_q        <= 16'd16384;
      gt_q        <= 18'd65536;
      pt_q        <= 16'sd0;
      sil_q       <= 1'b0;
      mas_q       <= 1'b0;
      pos_q       <= '0;
      now_q[0]    <= 20'sd16384;
      now_q[1]    <= 20'sd65536;
      now_q[2]    <= 20'sd65536;
      now_q[3]    <= 20'sd0;
      end_q[0]    <= 20'sd16384;
      end_q[1]    <= 20'sd65536;
      end_q[2]    <= 20'sd65536;
      end_q[3]    <= 20'sd0;
      cs_q[0]     <= 18'sd65536;
      cs_q[1]     <= 18'sd0;
      cs_q[2]     <= 18'sd0;
      cs_q[3]     <= 18'sd65536;
      ce_q[0]     <= 18'sd65536;
      ce_q[1]     <= 18'sd0;
      ce_q[2]     <= 18'sd0;
      ce_q[3]     <= 18'sd65536;
      for (int i = 0; i < 4; i++) begin
        peak_q[i] <= '0;
      end
      eacc_q[0]   <= '0;
      eacc_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BLOCK_LEN:     blen_q <= cfg_wdata_i[12:0];
          CFG_INV_BLOCK_LEN: inv_q  <= cfg_wdata_i[16:0];
          CFG_SMOOTH_COEF:   coef_q <= cfg_wdata_i[15:0];
          CFG_WIDTH_TARGET:  wt_q   <= cfg_wdata_i[15:0];
          CFG_GAIN_TARGET:   gt_q   <= cfg_wdata_i[17:0];
          CFG_PAN_TARGET:    pt_q   <= cfg_wdata_i[15:0];
          CFG_SILENCED:      sil_q  <= cfg_wdata_i[0];
          CFG_IS_MASTER:     mas_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.wb) begin
        case (cmd_i.op)
          OP_APP_W, OP_APP_G, OP_APP_M, OP_APP_P: begin
            // Snap to the target when the smoothed distance to it is within one LSB.
            if (app_mag <= 60'sd1) begin
              end_q[csel] <= tgt_c;
            end else if (cur_c >= tgt_c) begin
              end_q[csel] <= 20'(60'(tgt_c) + app_mag);
            end else begin
              end_q[csel] <= 20'(60'(tgt_c) - app_mag);
            end
          end
          OP_COS0: begin
            for (int i = 0; i < 4; i++) begin
              cs_q[i] <= mat[i];
            end
          end
          OP_COS1: begin
            for (int i = 0; i < 4; i++) begin
              ce_q[i] <= mat[i];
            end
          end
          OP_SQ_R:  eacc_q[0] <= e_new;
          OP_SQ_OR: eacc_q[1] <= e_new;
          default: ;
        endcase
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        if (last) begin
          for (int i = 0; i < 4; i++) begin
            now_q[i]  <= end_q[i];
            peak_q[i] <= '0;
          end
          eacc_q[0] <= '0;
          eacc_q[1] <= '0;
          pos_q     <= '0;
        end else begin
          for (int i = 0; i < 4; i++) begin
            peak_q[i] <= pk_n[i];
          end
          pos_q <= pos_q + 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q <= left_in_i;
      r_q <= right_in_i;
    end
    if (cmd_i.mul) begin
      prod_q <= 57'(mul_a) * 57'(mul_b);
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_SIN0, OP_SIN1: s_q <= sin_val;
        OP_T: t_q <= (prod_q > 57'sd65536) ? 17'd65536 : prod_q[16:0];
        OP_LERP_W:  lv_q[0] <= 20'(60'(lerp_s) + rnd16);
        OP_LERP_G:  lv_q[1] <= 20'(60'(lerp_s) + rnd16);
        OP_LERP_M:  lv_q[2] <= 20'(60'(lerp_s) + rnd16);
        OP_LERP_LL: lv_q[3] <= 20'(60'(lerp_s) + rnd16);
        OP_LERP_RL: lv_q[4] <= 20'(60'(lerp_s) + rnd16);
        OP_LERP_LR: lv_q[5] <= 20'(60'(lerp_s) + rnd16);
        OP_LERP_RR: lv_q[6] <= 20'(60'(lerp_s) + rnd16);
        OP_WID: begin
          a_q <= 32'(wid_a);
          b_q <= 32'(wid_b);
        end
        OP_GAIN: g_q <= 20'(rnd16);
        OP_AG:   a_q <= 32'(rnd16);
        OP_BG:   b_q <= 32'(rnd16);
        OP_PAN1, OP_PAN3, OP_SQ_L, OP_SQ_OL: acc_q <= 58'(prod_q);
        OP_PAN2: ol_q <= sat(pan_sum);
        OP_PAN4: or_q <= sat(pan_sum);
        default: ;
      endcase
    end
    if (cmd_i.fin) begin
      left_out_q  <= ol_q;
      right_out_q <= or_q;
      block_end_q <= last;
      for (int i = 0; i < 4; i++) begin
        opk_q[i] <= last ? 24'(pk_n[i]) : 24'd0;
      end
      oen_q[0] <= last ? eacc_q[0] : 59'd0;
      oen_q[1] <= last ? eacc_q[1] : 59'd0;
    end
  end

  assign sts_o.first    = (pos_q == '0);
  assign sts_o.out_hold = out_valid_q && out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign left_out_o        = left_out_q;
  assign right_out_o       = right_out_q;
  assign block_end_o       = block_end_q;
  assign pre_peak_left_o   = opk_q[0];
  assign pre_peak_right_o  = opk_q[1];
  assign post_peak_left_o  = opk_q[2];
  assign post_peak_right_o = opk_q[3];
  assign pre_energy_o      = oen_q[0];
  assign post_energy_o     = oen_q[1];

endmodule

// ----- rtl/stereo_strip_width_gain_pan_core.sv -----
// Top level of the stereo channel strip: width, gain with mute, equal-power pan and meters.
// Each item runs 20 multiply and write-back pairs on one shared multiplier.
// The first item of a control block adds 8 pairs for the smoothed end values and pan matrices.
// The result is registered when the sequencer leaves its final state, which waits while a held result is stalled;
// the input is stalled from acceptance until then, so a new item is taken only after the last one is through.
// Reset is asynchronous: all controls return to unity, pan centered, meters cleared.
`timescale 1ns / 1ps

module stereo_strip_width_gain_pan_core
  import sswgp_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          block_end_o,
  output logic [23:0]                   pre_peak_left_o,
  output logic [23:0]                   pre_peak_right_o,
  output logic [23:0]                   post_peak_left_o,
  output logic [23:0]                   post_peak_right_o,
  output logic [58:0]                   pre_energy_o,
  output logic [58:0]                   post_energy_o
);

  cmd_t cmd;
  sts_t sts;

  sswgp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sswgp_dpath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .left_in_i         (left_in_i),
    .right_in_i        (right_in_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .left_out_o        (left_out_o),
    .right_out_o       (right_out_o),
    .block_end_o       (block_end_o),
    .pre_peak_left_o   (pre_peak_left_o),
    .pre_peak_right_o  (pre_peak_right_o),
    .post_peak_left_o  (post_peak_left_o),
    .post_peak_right_o (post_peak_right_o),
    .pre_energy_o      (pre_energy_o),
    .post_energy_o     (post_energy_o)
  );

endmodule

// ----- rtl/sswgp_checker.sv -----
// Port-level checker for the channel strip, attached to the top level by a bind statement.
`timescale 1ns / 1ps

module sswgp_checker
  import sswgp_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_o,
  input logic signed [SAMPLE_BITS-1:0] right_out_o,
  input logic                          block_end_o,
  input logic [23:0]                   pre_peak_left_o,
  input logic [23:0]                   pre_peak_right_o,
  input logic [23:0]                   post_peak_left_o,
  input logic [23:0]                   post_peak_right_o,
  input logic [58:0]                   pre_energy_o,
  input logic [58:0]                   post_energy_o
);

  // Only one item is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is still in work");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_out_o) &&
    $stable(right_out_o) && $stable(block_end_o))
    else $error("stalled result changed");

  // Meters are zero except on the last item of a block.
  a_meters_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !block_end_o |-> pre_peak_left_o == 24'd0 &&
    pre_peak_right_o == 24'd0 && post_peak_left_o == 24'd0 &&
    post_peak_right_o == 24'd0 && pre_energy_o == 59'd0 && post_energy_o == 59'd0)
    else $error("meter fields set on a non-final item");

  // Peaks never exceed full-scale magnitude.
  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pre_peak_left_o <= 24'd8388608 && pre_peak_right_o <= 24'd8388608 &&
    post_peak_left_o <= 24'd8388608 && post_peak_right_o <= 24'd8388608)
    else $error("peak meter beyond full scale");

endmodule

bind stereo_strip_width_gain_pan_core sswgp_checker u_chk (.*);
